// ===== src/bls_pkg.sv =====
// Shared types, codes and default sizes for the bounded LIFO stack.
// Used by the controller, the datapath and the top level; depends on nothing.
package bls_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned POS_W     = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_DISPLAY = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RD_PTR    = 2'd0,
    RD_BOTTOM = 2'd1,
    RD_NEXT   = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    wr_en;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    idx_load;
    logic    idx_dec;
    logic    res_load;
    logic    res_read;
    status_e res_status;
    logic    res_last;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic walk_last;
  } stat_t;

endpackage

// ===== src/bls_ctrl.sv =====
// Command sequencer for the bounded LIFO stack.
// Depends on bls_pkg; drives the datapath through ctrl_t and reads stat_t.
module bls_ctrl
  import bls_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CMD_W-1:0] command_i,
  input  stat_t            stat_i,
  output ctrl_t            ctrl_o,
  output logic             busy_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_WALK
  } state_e;

  state_e state_q, state_d;
  logic   pop_q, pop_d;
  cmd_e   cmd;

  assign cmd    = cmd_e'(command_i);
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    pop_d   = pop_q;
    ctrl_o  = '{default: '0, rd_sel: RD_PTR, res_status: ST_OK};
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (cmd)
            CMD_PUSH: begin
              ctrl_o.res_load = 1'b1;
              ctrl_o.res_last = 1'b1;
              if (stat_i.full) begin
                ctrl_o.res_status = ST_OVERFLOW;
              end else begin
                ctrl_o.wr_en   = 1'b1;
                ctrl_o.ptr_dec = 1'b1;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (stat_i.empty) begin
                ctrl_o.res_load   = 1'b1;
                ctrl_o.res_last   = 1'b1;
                ctrl_o.res_status = ST_EMPTY;
              end else begin
                ctrl_o.rd_en  = 1'b1;
                ctrl_o.rd_sel = RD_PTR;
                pop_d         = (cmd == CMD_POP);
                state_d       = S_RESP;
              end
            end
            CMD_DISPLAY: begin
              if (stat_i.empty) begin
                ctrl_o.res_load   = 1'b1;
                ctrl_o.res_last   = 1'b1;
                ctrl_o.res_status = ST_EMPTY;
              end else begin
                ctrl_o.rd_en    = 1'b1;
                ctrl_o.rd_sel   = RD_BOTTOM;
                ctrl_o.idx_load = 1'b1;
                state_d         = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RESP: begin
        ctrl_o.res_load = 1'b1;
        ctrl_o.res_read = 1'b1;
        ctrl_o.res_last = 1'b1;
        ctrl_o.ptr_inc  = pop_q;
        state_d         = S_IDLE;
      end
      S_WALK: begin
        ctrl_o.res_load = 1'b1;
        ctrl_o.res_read = 1'b1;
        ctrl_o.res_last = stat_i.walk_last;
        if (stat_i.walk_last) begin
          state_d = S_IDLE;
        end else begin
          ctrl_o.rd_en   = 1'b1;
          ctrl_o.rd_sel  = RD_NEXT;
          ctrl_o.idx_dec = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pop_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pop_q   <= pop_d;
    end
  end

  a_rd_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_o.wr_en && ctrl_o.rd_en))
    else $error("Read and write issued in the same cycle.");

  a_resp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |-> $past(ctrl_o.rd_en))
    else $error("Response state entered without a memory read.");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.rd_en && !ctrl_o.res_load) |=> busy_o)
    else $error("Read data pending while the sequencer is idle.");

endmodule

// ===== src/bls_dpath.sv =====
// Entry memory, stack pointer, display index and result registers.
// Depends on bls_pkg; executes the ctrl_t commands from bls_ctrl.
module bls_dpath
  import bls_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_t                    ctrl_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output stat_t                    stat_o,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] data_value_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [POS_W-1:0]         pointer_position_o,
  output logic                     last_of_run_o
);

  localparam int unsigned PTR_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_q;

  logic [PTR_W-1:0]       ptr_q, ptr_d, ptr_m1;
  logic [ADDR_W-1:0]      idx_q, idx_d, rd_addr, wr_addr;
  logic [PTR_W+POS_W-1:0] ptr_ext;

  logic                     done_q;
  logic signed [DATA_W-1:0] res_data_q;
  status_e                  res_status_q;
  logic                     res_last_q;

  assign ptr_m1  = ptr_q - PTR_W'(1);
  assign wr_addr = ptr_m1[ADDR_W-1:0];

  assign stat_o.empty     = (ptr_q == PTR_W'(DEPTH));
  assign stat_o.full      = (ptr_q == '0);
  assign stat_o.walk_last = (PTR_W'(idx_q) == ptr_q);

  always_comb begin
    case (ctrl_i.rd_sel)
      RD_PTR:    rd_addr = ptr_q[ADDR_W-1:0];
      RD_BOTTOM: rd_addr = ADDR_W'(DEPTH - 1);
      RD_NEXT:   rd_addr = idx_q - ADDR_W'(1);
      default:   rd_addr = ptr_q[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    ptr_d = ptr_q;
    if (ctrl_i.ptr_dec) begin
      ptr_d = ptr_m1;
    end else if (ctrl_i.ptr_inc) begin
      ptr_d = ptr_q + PTR_W'(1);
    end
    idx_d = idx_q;
    if (ctrl_i.idx_load || ctrl_i.idx_dec) begin
      idx_d = rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr] <= push_value_i;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= PTR_W'(DEPTH);
      done_q <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      done_q <= ctrl_i.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (ctrl_i.res_load) begin
      res_data_q   <= ctrl_i.res_read ? rd_q : '0;
      res_status_q <= ctrl_i.res_status;
      res_last_q   <= ctrl_i.res_last;
    end
  end

  assign ptr_ext            = {{POS_W{1'b0}}, ptr_q};
  assign pointer_position_o = ptr_ext[POS_W-1:0];
  assign done_o             = done_q;
  assign data_value_o       = res_data_q;
  assign status_o           = res_status_q;
  assign last_of_run_o      = res_last_q;

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_W'(DEPTH))
    else $error("Stack pointer beyond the depth.");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.wr_en |-> !stat_o.full)
    else $error("Write issued while the stack is full.");

endmodule

// ===== src/bounded_lifo_stack.sv =====
// Bounded LIFO stack: push, pop and peek give one result each, display streams entries.
// Push, and any command that fails, gives its result in the cycle after acceptance; the next
// transaction can be accepted in that same cycle, one per cycle. Pop and peek read the
// registered memory port, then load the result registers. Display reads from the bottom
// entry up, then gives one result per cycle. Reset empties the stack; entry contents are
// undefined until pushed. Results cannot be stalled. Depends on bls_pkg, bls_ctrl, bls_dpath.
module bounded_lifo_stack
  import bls_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [CMD_W-1:0]         command_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] data_value_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [POS_W-1:0]         pointer_position_o,
  output logic                     last_of_run_o
);

  ctrl_t ctrl;
  stat_t stat;

  bls_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy_o    (busy_o)
  );

  bls_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .push_value_i       (push_value_i),
    .stat_o             (stat),
    .done_o             (done_o),
    .data_value_o       (data_value_o),
    .status_o           (status_o),
    .pointer_position_o (pointer_position_o),
    .last_of_run_o      (last_of_run_o)
  );

endmodule

// ===== tb/tb_bounded_lifo_stack.sv =====
// Self-checking testbench for bounded_lifo_stack: it drives push, pop, peek and display
// commands and checks every result strobe against a stack model in a scoreboard class.
// Depends on bls_pkg and the bounded_lifo_stack RTL.
module tb_bounded_lifo_stack
  import bls_pkg::*;
();

  localparam int unsigned STACK_DEPTH = DEPTH_DEF;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS = 87;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    status_e                  status;
    logic [POS_W-1:0]         pos;
    logic                     last;
  } stack_result_t;

  class stack_scoreboard;
    logic signed [DATA_W-1:0] entries[STACK_DEPTH];
    int unsigned              sp;
    stack_result_t            expected_q[$];
    int unsigned              errors;

    function new();
      foreach (entries[i]) entries[i] = '0;
      sp = STACK_DEPTH;
      errors = 0;
    endfunction

    function void add_result(logic signed [DATA_W-1:0] data, status_e status, logic last);
      stack_result_t r;
      r.data = data;
      r.status = status;
      r.pos = sp[POS_W-1:0];
      r.last = last;
      expected_q.push_back(r);
    endfunction

    function void note_command(cmd_e cmd, logic signed [DATA_W-1:0] value);
      int idx;
      case (cmd)
        CMD_PUSH: begin
          if (sp == 0) begin
            add_result('0, ST_OVERFLOW, 1'b1);
          end else begin
            sp--;
            entries[sp] = value;
            add_result('0, ST_OK, 1'b1);
          end
        end
        CMD_POP: begin
          if (sp >= STACK_DEPTH) begin
            add_result('0, ST_EMPTY, 1'b1);
          end else begin
            sp++;
            add_result(entries[sp-1], ST_OK, 1'b1);
          end
        end
        CMD_PEEK: begin
          if (sp >= STACK_DEPTH) add_result('0, ST_EMPTY, 1'b1);
          else add_result(entries[sp], ST_OK, 1'b1);
        end
        default: begin
          if (sp >= STACK_DEPTH) begin
            add_result('0, ST_EMPTY, 1'b1);
          end else begin
            for (idx = STACK_DEPTH - 1; idx >= int'(sp); idx--) begin
              add_result(entries[idx], ST_OK, idx == int'(sp));
            end
          end
        end
      endcase
    endfunction

    function void check_result(logic signed [DATA_W-1:0] data, logic [STATUS_W-1:0] status,
                               logic [POS_W-1:0] pos, logic last);
      stack_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: data %0d status %0d pos %0d last %0d",
                   data, status, pos, last);
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data || status !== e.status || pos !== e.pos || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected data %0d status %0d pos %0d last %0d, got %0d %0d %0d %0d",
                   e.data, e.status, e.pos, e.last, data, status, pos, last);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [CMD_W-1:0]         command_i;
  logic signed [DATA_W-1:0] push_value_i;
  logic                     done_o;
  logic signed [DATA_W-1:0] data_value_o;
  logic [STATUS_W-1:0]      status_o;
  logic [POS_W-1:0]         pointer_position_o;
  logic                     last_of_run_o;

  stack_scoreboard sb;
  int unsigned     quiet_cycles = 0;

  bounded_lifo_stack #(
    .DEPTH(STACK_DEPTH)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .command_i         (command_i),
    .push_value_i      (push_value_i),
    .done_o            (done_o),
    .data_value_o      (data_value_o),
    .status_o          (status_o),
    .pointer_position_o(pointer_position_o),
    .last_of_run_o     (last_of_run_o)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_command(cmd_e'(command_i), push_value_i);
      if (done_o) sb.check_result(data_value_o, status_o, pointer_position_o, last_of_run_o);
      if ((start_i && !busy_o) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_command(cmd_e cmd, logic signed [DATA_W-1:0] value);
    start_i      <= 1'b1;
    command_i    <= cmd;
    push_value_i <= value;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic hold_off(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_e pick_command(int unsigned push_weight);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < push_weight) return CMD_PUSH;
    roll = $urandom_range(0, 9);
    if (roll < 5) return CMD_POP;
    if (roll < 8) return CMD_PEEK;
    return CMD_DISPLAY;
  endfunction

  initial begin
    int unsigned push_weight;
    sb           = new();
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    command_i    = CMD_PUSH;
    push_value_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty-stack cases, then fill to the top with extreme values and overflow once.
    send_command(CMD_POP, $urandom);
    send_command(CMD_PEEK, $urandom);
    send_command(CMD_DISPLAY, $urandom);
    send_command(CMD_PUSH, 32'h8000_0000);
    send_command(CMD_PUSH, 32'h7fff_ffff);
    send_command(CMD_PUSH, '0);
    send_command(CMD_PUSH, '1);
    send_command(CMD_PUSH, 32'haaaa_aaaa);
    send_command(CMD_PUSH, 32'h5555_5555);
    send_command(CMD_PUSH, 32'h0000_0001);
    send_command(CMD_PUSH, 32'hffff_fffe);
    send_command(CMD_PUSH, 32'h1234_5678);
    send_command(CMD_PEEK, '0);
    send_command(CMD_DISPLAY, '1);
    repeat (STACK_DEPTH) send_command(CMD_POP, $urandom);
    send_command(CMD_POP, $urandom);

    push_weight = 50;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 15 == 0) begin
        case ($urandom_range(0, 2))
          0: push_weight = 20;
          1: push_weight = 50;
          default: push_weight = 85;
        endcase
      end
      if (n == 55) begin
        start_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
      end
      send_command(pick_command(push_weight), pick_value());
      if (n < RANDOM_ITEMS - 25 && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 11));
    end
    start_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (STACK_DEPTH + 4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/bls_pkg.sv
src/bls_ctrl.sv
src/bls_dpath.sv
src/bounded_lifo_stack.sv
tb/tb_bounded_lifo_stack.sv
